>>> rtl/core/cbss_pkg.sv
// ----------------------------------------------------------------------------
// cbss_pkg
// Shared types and constants of the CDF binary search sampler: field widths,
// stream packing offsets, codes and the controller/datapath command bundles.
// ----------------------------------------------------------------------------
package cbss_pkg;

    // Default table depth handed down from the top level
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    // Field widths fixed by the item format
    localparam int KIND_W   = 1;
    localparam int EIDX_W   = 10;
    localparam int WEIGHT_W = 32;
    localparam int COUNT_W  = 11;
    localparam int CIDX_W   = 10;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Slave-side tdata layout, lowest bit first, padded to whole bytes
    localparam int S_EIDX_LSB   = 0;
    localparam int S_EWGT_LSB   = S_EIDX_LSB + EIDX_W;
    localparam int S_TWGT_LSB   = S_EWGT_LSB + WEIGHT_W;
    localparam int S_PAYLOAD_W  = S_TWGT_LSB + WEIGHT_W;
    localparam int S_TDATA_W    = ((S_PAYLOAD_W + 7) / 8) * 8;

    // Master-side tdata layout
    localparam int M_TDATA_W    = ((CIDX_W + 7) / 8) * 8;

    // Item kinds carried in tuser
    localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_WEIGHT = 8'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic wr;        // store the incoming table entry
        logic load;      // capture target and clamped count, set search bounds
        logic rd;        // read the table at the current midpoint
        logic cmp;       // narrow the bounds from the read data
        logic load_out;  // move the answer into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic edge_hit;  // empty table, zero target or target at/above total
        logic converged; // search bounds have met
    } t_status;

endpackage

>>> rtl/core/cbss_datapath.sv
// ----------------------------------------------------------------------------
// cbss_datapath
// Table memory, configuration registers, search bounds and the output
// register of the CDF binary search sampler.
// ----------------------------------------------------------------------------
module cbss_datapath
    import cbss_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [EIDX_W-1:0]     i_entry_index,
    input  logic [WEIGHT_W-1:0]   i_entry_weight,
    input  logic [WEIGHT_W-1:0]   i_query_key,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_found,
    output logic [CIDX_W-1:0]     o_chosen_index
);

    localparam int IW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [WEIGHT_W-1:0] r_mem [TABLE_DEPTH];

    logic [COUNT_W-1:0]  r_entry_count;
    logic [WEIGHT_W-1:0] r_total_weight;
    logic [WEIGHT_W-1:0] r_target;
    logic [CW-1:0]       r_n;
    logic [IW-1:0]       r_lo;
    logic [IW-1:0]       r_hi;
    logic [IW-1:0]       r_mid;
    logic [WEIGHT_W-1:0] r_rdata;
    logic                r_found;
    logic [CIDX_W-1:0]   r_chosen_index;

    logic [CW-1:0]       n_n;
    logic [IW-1:0]       mid;
    logic [31:0]         wr_pos;
    logic                empty;
    logic                zero_target;
    logic                over_total;
    logic [IW-1:0]       result_idx;
    logic [31:0]         result_ext;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count  <= '0;
            r_total_weight <= '0;
        end else if (i_cfg_wr) begin
            if (i_cfg_index == REG_ENTRY_COUNT) begin
                r_entry_count <= i_cfg_data[COUNT_W-1:0];
            end else if (i_cfg_index == REG_TOTAL_WEIGHT) begin
                r_total_weight <= i_cfg_data;
            end
        end
    end

    // Table memory: one write port, one registered read port
    assign wr_pos = {{(32-EIDX_W){1'b0}}, i_entry_index};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && (wr_pos < 32'(TABLE_DEPTH))) begin
            r_mem[wr_pos[IW-1:0]] <= i_entry_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rdata <= r_mem[mid];
        end
    end

    // Clamp the count to the table depth
    always_comb begin
        if ({{(32-COUNT_W){1'b0}}, r_entry_count} > 32'(TABLE_DEPTH)) begin
            n_n = CW'(TABLE_DEPTH);
        end else begin
            n_n = CW'(r_entry_count);
        end
    end

    assign mid = r_lo + ((r_hi - r_lo) >> 1);

    // Search bounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target <= i_query_key;
            r_n      <= n_n;
            r_lo     <= '0;
            r_hi     <= IW'(n_n - CW'(1));
        end else begin
            if (i_cmd.rd) begin
                r_mid <= mid;
            end
            if (i_cmd.cmp) begin
                if (r_target <= r_rdata) begin
                    r_hi <= r_mid;
                end else begin
                    r_lo <= r_mid + IW'(1);
                end
            end
        end
    end

    assign empty       = (r_n == '0);
    assign zero_target = (r_target == '0);
    assign over_total  = (r_target >= r_total_weight);

    assign o_status.edge_hit  = empty || zero_target || over_total;
    assign o_status.converged = (r_lo >= r_hi);

    // Zero target wins over the total check; over total picks the last index
    always_comb begin
        if (empty || zero_target) begin
            result_idx = '0;
        end else if (over_total) begin
            result_idx = r_hi;
        end else begin
            result_idx = r_lo;
        end
    end

    assign result_ext = 32'(result_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_found        <= !empty;
            r_chosen_index <= result_ext[CIDX_W-1:0];
        end
    end

    assign o_found        = r_found;
    assign o_chosen_index = r_chosen_index;

    a_read_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (r_lo < r_hi))
        else $error("table read issued with collapsed search bounds");

    a_bounds_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cmp |=> (r_lo <= r_hi))
        else $error("search bounds crossed after a compare step");

endmodule

>>> rtl/core/cbss_ctrl.sv
// ----------------------------------------------------------------------------
// cbss_ctrl
// Sequencer of the CDF binary search sampler: input handshake, search loop
// and result valid.
// ----------------------------------------------------------------------------
module cbss_ctrl
    import cbss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    input  logic [KIND_W-1:0] i_s_kind,
    output logic              o_s_ready,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    input  t_status           i_status,
    output t_cmd              o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_ADDR  = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       s_accept;
    logic       out_free;

    assign o_s_ready = (r_state == ST_IDLE);
    assign s_accept  = i_s_valid && o_s_ready;
    assign out_free  = !r_out_valid || i_m_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    if (i_s_kind == KIND_QUERY) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_CHECK;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                if (i_status.edge_hit) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                if (i_status.converged) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_CMP;
                end
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = ST_ADDR;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_valid = r_out_valid;

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_ready) |=> r_out_valid)
        else $error("pending result dropped before it was taken");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_m_ready))
        else $error("output register overwritten while still pending");

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (i_s_kind == KIND_QUERY)) |=> (r_state == ST_CHECK))
        else $error("accepted query did not start a search");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (i_s_kind == KIND_WRITE)) |=> !o_cmd.load_out)
        else $error("write transaction produced a result");

endmodule

>>> rtl/core/cdf_binary_search_sampler.sv
// ----------------------------------------------------------------------------
// cdf_binary_search_sampler
// Inverse-CDF index selection by binary search over a table of ascending
// cumulative 16.16 weights.
// ----------------------------------------------------------------------------
// A write transaction (tuser kind 0) stores one cumulative weight and gives
// no result. A query transaction (kind 1) returns the first index whose
// stored weight is at or above the target: a zero target gives index 0, a
// target at or above total_weight gives the last index in use, and an empty
// table (entry_count 0) returns found = 0. Entry counts above the table
// depth are clamped to it. A query first checks the edge cases, then runs
// halving steps - one registered read of the table at the midpoint and one
// compare - until the bounds meet, and then loads the output register; an
// edge case goes straight to the output register. A stalled master side
// holds that last step until the output register frees up. The table read
// latency sets this loop. One item is worked on at a time; a new transaction
// is taken while the previous result still waits on the master side. Reading
// an entry never written since reset gives an undefined index. Configuration
// writes are always taken (o_cfg_ready is held high) and must only happen
// while the block is idle.
// ----------------------------------------------------------------------------
module cdf_binary_search_sampler
    import cbss_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // slave side
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: entry_index[9:0], entry_weight[41:10], query_key[73:42], zero pad
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: kind[0]
    input  logic [KIND_W-1:0]     i_s_axis_tuser,
    // master side
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: chosen_index[9:0], zero pad
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    // tuser: found[0]
    output logic [0:0]            o_m_axis_tuser
);

    t_cmd              cmd;
    t_status           status;
    logic              found;
    logic [CIDX_W-1:0] chosen_index;

    // Configuration never stalls
    assign o_cfg_ready = 1'b1;

    cbss_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_s_kind  (i_s_axis_tuser),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    cbss_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_entry_index   (i_s_axis_tdata[S_EIDX_LSB +: EIDX_W]),
        .i_entry_weight  (i_s_axis_tdata[S_EWGT_LSB +: WEIGHT_W]),
        .i_query_key     (i_s_axis_tdata[S_TWGT_LSB +: WEIGHT_W]),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_found         (found),
        .o_chosen_index  (chosen_index)
    );

    // Pack the result, padding tdata to whole bytes
    assign o_m_axis_tdata = {{(M_TDATA_W-CIDX_W){1'b0}}, chosen_index};
    assign o_m_axis_tuser = found;

endmodule
